### rtl/sff_pkg.sv
package sff_pkg;

   localparam int FORCE_WIDTH = 24;
   localparam int COUNTER_WIDTH_DEF = 8;
   localparam int AXES = 6;

   localparam int MODE_WIDTH = 2;
   localparam int THR_WIDTH = 23;
   localparam int LIMIT_WIDTH = 8;
   localparam int GAIN_THR_WIDTH = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 23;

   localparam int LEVEL_WIDTH = 3;
   localparam int GAIN_WIDTH = 8;
   localparam int GAIN_SHIFT = 8;

   localparam logic [GAIN_THR_WIDTH-1:0] STEP_ADD = GAIN_THR_WIDTH'(5);
   localparam logic [LEVEL_WIDTH-1:0] GAIN_MAX_LEVEL = LEVEL_WIDTH'(4);

   localparam logic [MODE_WIDTH-1:0] MODE_PASS = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_JITTER = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_LOWPASS = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JITTER_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JITTER_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWPASS_STEP_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWPASS_GAIN_THRESHOLD = 3'd4;

   typedef struct packed {
      logic signed [FORCE_WIDTH-1:0] force_x;
      logic signed [FORCE_WIDTH-1:0] force_y;
      logic signed [FORCE_WIDTH-1:0] force_z;
      logic signed [FORCE_WIDTH-1:0] torque_x;
      logic signed [FORCE_WIDTH-1:0] torque_y;
      logic signed [FORCE_WIDTH-1:0] torque_z;
   } req_type;

   typedef struct packed {
      logic signed [FORCE_WIDTH-1:0] filtered_force_x;
      logic signed [FORCE_WIDTH-1:0] filtered_force_y;
      logic signed [FORCE_WIDTH-1:0] filtered_force_z;
      logic signed [FORCE_WIDTH-1:0] filtered_torque_x;
      logic signed [FORCE_WIDTH-1:0] filtered_torque_y;
      logic signed [FORCE_WIDTH-1:0] filtered_torque_z;
   } rsp_type;

   typedef struct packed {
      logic                      flag;
      logic [GAIN_THR_WIDTH-1:0] steps;
      logic [LEVEL_WIDTH-1:0]    level;
   } lp_carry_type;

   function automatic logic [GAIN_WIDTH-1:0] gain_of(input logic [LEVEL_WIDTH-1:0] level);
      logic [GAIN_WIDTH-1:0] g;
      case (level)
         3'd0:    g = 8'd51;
         3'd1:    g = 8'd102;
         3'd2:    g = 8'd154;
         3'd3:    g = 8'd205;
         default: g = 8'd243;
      endcase
      return g;
   endfunction

endpackage

### rtl/sff_jitter_lane.sv
module sff_jitter_lane #(
   parameter int CNT_WIDTH = sff_pkg::COUNTER_WIDTH_DEF
) (
   input  logic signed [sff_pkg::FORCE_WIDTH-1:0] sample,
   input  logic signed [sff_pkg::FORCE_WIDTH-1:0] held,
   input  logic [CNT_WIDTH-1:0]                   count,
   input  logic [sff_pkg::THR_WIDTH-1:0]          threshold,
   input  logic [sff_pkg::LIMIT_WIDTH-1:0]        limit,
   output logic signed [sff_pkg::FORCE_WIDTH-1:0] held_out,
   output logic [CNT_WIDTH-1:0]                   count_out
);

   localparam int FW = sff_pkg::FORCE_WIDTH;
   localparam int DW = FW + 1;
   localparam int TW = sff_pkg::THR_WIDTH;
   localparam int CW = (DW > TW) ? DW : TW;
   localparam int LW = sff_pkg::LIMIT_WIDTH;
   localparam int KW = (CNT_WIDTH > LW) ? CNT_WIDTH : LW;

   logic signed [DW-1:0] diff;
   logic [DW-1:0]        mag;
   logic                 big;
   logic [CNT_WIDTH-1:0] count_inc;
   logic                 at_limit;

   assign diff = DW'(held) - DW'(sample);
   assign mag = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
   assign big = CW'(mag) > CW'(threshold);
   assign count_inc = count + CNT_WIDTH'(1);
   assign at_limit = KW'(count_inc) >= KW'(limit);

   always_comb begin
      held_out = held;
      count_out = count;
      if (big) begin
         if (at_limit) begin
            held_out = sample;
            count_out = '0;
         end else begin
            count_out = count_inc;
         end
      end
   end

endmodule

### rtl/sff_lowpass_lane.sv
module sff_lowpass_lane (
   input  logic signed [sff_pkg::FORCE_WIDTH-1:0] sample,
   input  logic signed [sff_pkg::FORCE_WIDTH-1:0] held,
   input  sff_pkg::lp_carry_type                  carry_in,
   input  logic [sff_pkg::THR_WIDTH-1:0]          step_threshold,
   input  logic [sff_pkg::GAIN_THR_WIDTH-1:0]     gain_threshold,
   output sff_pkg::lp_carry_type                  carry_out,
   output logic signed [sff_pkg::FORCE_WIDTH-1:0] held_out
);

   localparam int FW = sff_pkg::FORCE_WIDTH;
   localparam int DW = FW + 1;
   localparam int TW = sff_pkg::THR_WIDTH;
   localparam int CW = (DW > TW) ? DW : TW;
   localparam int PW = DW + sff_pkg::GAIN_WIDTH + 1;

   logic signed [DW-1:0]             diff;
   logic [DW-1:0]                    mag;
   logic                             dir;
   logic                             big;
   logic [sff_pkg::GAIN_THR_WIDTH-1:0] steps_add;
   logic [sff_pkg::GAIN_WIDTH-1:0]   gain;
   logic signed [PW-1:0]             prod;
   logic signed [PW-1:0]             sum;

   assign diff = DW'(held) - DW'(sample);
   assign mag = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
   assign dir = diff > 0;
   assign big = CW'(mag) > CW'(step_threshold);
   assign steps_add = big ? carry_in.steps + sff_pkg::STEP_ADD : carry_in.steps;

   always_comb begin
      carry_out = carry_in;
      if (dir == carry_in.flag) begin
         carry_out.steps = steps_add;
         if (steps_add >= gain_threshold && carry_in.level < sff_pkg::GAIN_MAX_LEVEL) begin
            carry_out.level = carry_in.level + sff_pkg::LEVEL_WIDTH'(1);
         end
      end else begin
         carry_out.flag = dir;
         carry_out.steps = '0;
         carry_out.level = '0;
      end
   end

   assign gain = sff_pkg::gain_of(carry_out.level);
   assign prod = PW'($signed({1'b0, gain})) * PW'(diff);
   assign sum = PW'(sample) + (prod >>> sff_pkg::GAIN_SHIFT);
   assign held_out = sum[FW-1:0];

endmodule

### rtl/six_axis_force_filter.sv
// A word accepted on req_ waits in the input register until the result register
// is empty or being read, then moves there and shows on rsp_. Throughput: one
// word per cycle while rsp_ready stays high; an input register and a result
// register carry the words, and the held outputs update as a word leaves the
// input stage. Reset: held outputs and jitter counters clear, registers take
// their reset values, and both stages empty.
module six_axis_force_filter #(
   parameter int COUNTER_WIDTH = sff_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  sff_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output sff_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sff_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sff_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int FW = sff_pkg::FORCE_WIDTH;
   localparam int AXES = sff_pkg::AXES;

   logic [sff_pkg::MODE_WIDTH-1:0]     mode_ff;
   logic [sff_pkg::THR_WIDTH-1:0]      jit_thr_ff;
   logic [sff_pkg::LIMIT_WIDTH-1:0]    jit_limit_ff;
   logic [sff_pkg::THR_WIDTH-1:0]      lp_step_thr_ff;
   logic [sff_pkg::GAIN_THR_WIDTH-1:0] lp_gain_thr_ff;

   logic             stage_valid_ff;
   sff_pkg::req_type stage_data_ff;
   logic             rsp_valid_ff;
   sff_pkg::rsp_type rsp_data_ff;
   sff_pkg::rsp_type rsp_data_in;

   logic signed [FW-1:0]      held_ff [AXES];
   logic signed [FW-1:0]      held_in [AXES];
   logic [COUNTER_WIDTH-1:0]  cnt_ff [AXES];
   logic [COUNTER_WIDTH-1:0]  cnt_in [AXES];

   logic signed [FW-1:0]      sample [AXES];
   logic signed [FW-1:0]      jit_held [AXES];
   logic [COUNTER_WIDTH-1:0]  jit_cnt [AXES];
   logic signed [FW-1:0]      lp_held [AXES];
   sff_pkg::lp_carry_type     lp_carry [AXES+1];

   logic advance;

   assign advance = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sff_pkg::MODE_LOWPASS;
         jit_thr_ff <= sff_pkg::THR_WIDTH'(256);
         jit_limit_ff <= sff_pkg::LIMIT_WIDTH'(5);
         lp_step_thr_ff <= sff_pkg::THR_WIDTH'(256);
         lp_gain_thr_ff <= sff_pkg::GAIN_THR_WIDTH'(10);
      end else if (csr_valid) begin
         unique case (csr_index)
            sff_pkg::CSR_FILTER_MODE:
               mode_ff <= csr_data[sff_pkg::MODE_WIDTH-1:0];
            sff_pkg::CSR_JITTER_THRESHOLD:
               jit_thr_ff <= csr_data[sff_pkg::THR_WIDTH-1:0];
            sff_pkg::CSR_JITTER_LIMIT:
               jit_limit_ff <= csr_data[sff_pkg::LIMIT_WIDTH-1:0];
            sff_pkg::CSR_LOWPASS_STEP_THRESHOLD:
               lp_step_thr_ff <= csr_data[sff_pkg::THR_WIDTH-1:0];
            sff_pkg::CSR_LOWPASS_GAIN_THRESHOLD:
               lp_gain_thr_ff <= csr_data[sff_pkg::GAIN_THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign sample[0] = stage_data_ff.force_x;
   assign sample[1] = stage_data_ff.force_y;
   assign sample[2] = stage_data_ff.force_z;
   assign sample[3] = stage_data_ff.torque_x;
   assign sample[4] = stage_data_ff.torque_y;
   assign sample[5] = stage_data_ff.torque_z;

   assign lp_carry[0] = '0;

   for (genvar i = 0; i < AXES; i++) begin : g_axis
      sff_jitter_lane #(
         .CNT_WIDTH(COUNTER_WIDTH)
      ) u_jitter (
         .sample(sample[i]),
         .held(held_ff[i]),
         .count(cnt_ff[i]),
         .threshold(jit_thr_ff),
         .limit(jit_limit_ff),
         .held_out(jit_held[i]),
         .count_out(jit_cnt[i])
      );

      sff_lowpass_lane u_lowpass (
         .sample(sample[i]),
         .held(held_ff[i]),
         .carry_in(lp_carry[i]),
         .step_threshold(lp_step_thr_ff),
         .gain_threshold(lp_gain_thr_ff),
         .carry_out(lp_carry[i+1]),
         .held_out(lp_held[i])
      );

      always_comb begin
         held_in[i] = held_ff[i];
         cnt_in[i] = cnt_ff[i];
         case (mode_ff)
            sff_pkg::MODE_PASS: begin
               held_in[i] = sample[i];
            end
            sff_pkg::MODE_JITTER: begin
               held_in[i] = jit_held[i];
               cnt_in[i] = jit_cnt[i];
            end
            sff_pkg::MODE_LOWPASS: begin
               held_in[i] = lp_held[i];
            end
            default: ;
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            held_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end else if (advance) begin
            held_ff[i] <= held_in[i];
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign rsp_data_in.filtered_force_x = held_in[0];
   assign rsp_data_in.filtered_force_y = held_in[1];
   assign rsp_data_in.filtered_force_z = held_in[2];
   assign rsp_data_in.filtered_torque_x = held_in[3];
   assign rsp_data_in.filtered_torque_y = held_in[4];
   assign rsp_data_in.filtered_torque_z = held_in[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### tb/six_axis_force_filter_tb.sv
`timescale 1ns / 100ps

module six_axis_force_filter_tb;
   import sff_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd7;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
   localparam longint FORCE_MAX = (longint'(1) <<< (FORCE_WIDTH - 1)) - 1;
   localparam longint FORCE_MIN = -(longint'(1) <<< (FORCE_WIDTH - 1));
   localparam logic [THR_WIDTH-1:0] THR_MAX = '1;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = '1;
   localparam logic [GAIN_THR_WIDTH-1:0] GAIN_THR_MAX = '1;
   localparam int STEP_GROWTH = 5;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS = 100;
   localparam int LONG_HOLD = 60;

   typedef struct {
      bit                         is_write;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  value;
      req_type                    sample;
      bit                         known;
      rsp_type                    want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   logic [MODE_WIDTH-1:0] mode_reg = MODE_LOWPASS;
   logic [THR_WIDTH-1:0] jitter_thr = 23'd256;
   logic [LIMIT_WIDTH-1:0] jitter_lim = 8'd5;
   logic [THR_WIDTH-1:0] step_thr = 23'd256;
   logic [GAIN_THR_WIDTH-1:0] gain_thr = 6'd10;
   logic signed [FORCE_WIDTH-1:0] held_axis [AXES];
   logic [COUNTER_WIDTH_DEF-1:0] jitter_count [AXES];
   longint last_in [AXES];
   int gain_by_level [5] = '{51, 102, 154, 205, 243};
   string axis_name [AXES] = '{"filtered_force_x", "filtered_force_y", "filtered_force_z",
                               "filtered_torque_x", "filtered_torque_y", "filtered_torque_z"};

   rsp_type expected_filtered [$];
   plan_row_type directed_rows [$];
   int mismatch_count = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit hold_req = 1'b0;

   six_axis_force_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic signed [FORCE_WIDTH-1:0] axis_of(
      input logic [AXES*FORCE_WIDTH-1:0] w, input int i);
      return w[(AXES-1-i)*FORCE_WIDTH +: FORCE_WIDTH];
   endfunction

   function automatic req_type make_sample(input longint a0, a1, a2, a3, a4, a5);
      return {a0[FORCE_WIDTH-1:0], a1[FORCE_WIDTH-1:0], a2[FORCE_WIDTH-1:0],
              a3[FORCE_WIDTH-1:0], a4[FORCE_WIDTH-1:0], a5[FORCE_WIDTH-1:0]};
   endfunction

   function automatic rsp_type filter_sample(input req_type s);
      longint in_v [AXES];
      longint d;
      longint mag;
      int steps;
      int level;
      bit flag;
      bit dir;
      steps = 0;
      level = 0;
      flag = 1'b0;
      for (int i = 0; i < AXES; i++) in_v[i] = axis_of(s, i);
      case (mode_reg)
         MODE_PASS: begin
            for (int i = 0; i < AXES; i++) held_axis[i] = in_v[i][FORCE_WIDTH-1:0];
         end
         MODE_JITTER: begin
            for (int i = 0; i < AXES; i++) begin
               d = held_axis[i] - in_v[i];
               mag = (d < 0) ? -d : d;
               if (mag > longint'(jitter_thr)) begin
                  jitter_count[i] = jitter_count[i] + 1'b1;
                  if (jitter_count[i] >= jitter_lim) begin
                     held_axis[i] = in_v[i][FORCE_WIDTH-1:0];
                     jitter_count[i] = '0;
                  end
               end
            end
         end
         MODE_LOWPASS: begin
            for (int i = 0; i < AXES; i++) begin
               d = held_axis[i] - in_v[i];
               mag = (d < 0) ? -d : d;
               dir = (d > 0);
               if (dir == flag) begin
                  if (mag > longint'(step_thr)) steps += STEP_GROWTH;
                  if (steps >= int'(gain_thr) && level < int'(GAIN_MAX_LEVEL)) level++;
               end else begin
                  steps = 0;
                  level = 0;
                  flag = dir;
               end
               d = in_v[i] + ((longint'(gain_by_level[level]) * d) >>> GAIN_SHIFT);
               held_axis[i] = d[FORCE_WIDTH-1:0];
            end
         end
         default: begin
         end
      endcase
      return {held_axis[0], held_axis[1], held_axis[2],
              held_axis[3], held_axis[4], held_axis[5]};
   endfunction

   function automatic req_type random_sample();
      longint v [AXES];
      longint step;
      logic signed [FORCE_WIDTH-1:0] t;
      int kind;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) step = longint'($urandom_range(0, 4194304));
      else step = longint'($urandom_range(0, 4000));
      if ($urandom_range(0, 1) == 1) step = -step;
      for (int i = 0; i < AXES; i++) begin
         if (kind < 20) begin
            t = FORCE_WIDTH'($urandom);
            v[i] = t;
         end else if (kind < 60) begin
            v[i] = last_in[i] + longint'($urandom_range(0, 1200)) - 600;
         end else if (kind < 85) begin
            v[i] = longint'(held_axis[i]) + step;
         end else begin
            case ($urandom_range(0, 4))
               0: v[i] = FORCE_MAX;
               1: v[i] = FORCE_MIN;
               2: v[i] = 0;
               3: v[i] = -1;
               default: v[i] = 1;
            endcase
         end
         if (v[i] > FORCE_MAX) v[i] = FORCE_MAX;
         else if (v[i] < FORCE_MIN) v[i] = FORCE_MIN;
         last_in[i] = v[i];
      end
      return make_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
   endfunction

   function automatic logic [THR_WIDTH-1:0] pick_threshold();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return THR_MAX;
         default: return THR_WIDTH'($urandom_range(0, 3000));
      endcase
   endfunction

   function automatic void plan_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                      input logic [CSR_DATA_WIDTH-1:0] val);
      plan_row_type row;
      row = '{1'b1, idx, val, '0, 1'b0, '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void plan_sample(input req_type s, input bit known, input rsp_type want);
      plan_row_type row;
      row = '{1'b0, '0, '0, s, known, want};
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic send_word(input req_type s, input bit known, input rsp_type want);
      int gap;
      rsp_type predicted;
      gap = req_burst ? 0 : $urandom_range(0, 5);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      predicted = filter_sample(s);
      expected_filtered.push_back(known ? want : predicted);
      if ($urandom_range(0, 49) == 0) req_burst = !req_burst;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FILTER_MODE:            mode_reg = val[MODE_WIDTH-1:0];
         CSR_JITTER_THRESHOLD:       jitter_thr = val[THR_WIDTH-1:0];
         CSR_JITTER_LIMIT:           jitter_lim = val[LIMIT_WIDTH-1:0];
         CSR_LOWPASS_STEP_THRESHOLD: step_thr = val[THR_WIDTH-1:0];
         CSR_LOWPASS_GAIN_THRESHOLD: gain_thr = val[GAIN_THR_WIDTH-1:0];
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_filtered.size() == 0) begin
            report_mismatch("result word with no expectation waiting");
         end else begin
            want = expected_filtered.pop_front();
            for (int i = 0; i < AXES; i++) begin
               if (axis_of(rsp_data, i) !== axis_of(want, i))
                  report_mismatch($sformatf("%s got %0d expected %0d", axis_name[i],
                                            axis_of(rsp_data, i), axis_of(want, i)));
            end
         end
      end
   end

   initial begin
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
      end
   end

   initial begin
      req_type e1;
      req_type e2;
      req_type e3;
      req_type e4;
      logic [MODE_WIDTH-1:0] mode_pick;
      logic [LIMIT_WIDTH-1:0] limit_pick;
      logic [GAIN_THR_WIDTH-1:0] gain_pick;

      for (int i = 0; i < AXES; i++) begin
         held_axis[i] = '0;
         jitter_count[i] = '0;
         last_in[i] = 0;
      end

      e1 = make_sample(FORCE_MAX, FORCE_MIN, 0, -1, 1, FORCE_MIN);
      e2 = make_sample(FORCE_MIN, FORCE_MAX, -1, 0, FORCE_MIN, FORCE_MAX);
      e3 = make_sample(FORCE_MAX, FORCE_MAX, FORCE_MAX, FORCE_MAX, FORCE_MAX, FORCE_MAX);
      e4 = make_sample(FORCE_MIN, FORCE_MIN, FORCE_MIN, FORCE_MIN, FORCE_MIN, FORCE_MIN);

      plan_sample('0, 1'b1, '0);
      plan_sample(make_sample(256, -256, 300, -300, 5000, -5000), 1'b0, '0);
      plan_sample(e3, 1'b0, '0);
      plan_write(CSR_FILTER_MODE, CSR_DATA_WIDTH'(MODE_PASS));
      plan_sample(e1, 1'b1, rsp_type'(e1));
      plan_sample(e2, 1'b1, rsp_type'(e2));
      plan_write(CSR_FILTER_MODE, CSR_DATA_WIDTH'(MODE_SPARE));
      plan_sample(e1, 1'b1, rsp_type'(e2));
      plan_write(CSR_FILTER_MODE, CSR_DATA_WIDTH'(MODE_JITTER));
      plan_write(CSR_JITTER_LIMIT, '0);
      plan_write(CSR_JITTER_THRESHOLD, '0);
      plan_sample(e3, 1'b1, rsp_type'(e3));
      plan_sample(e3, 1'b1, rsp_type'(e3));
      plan_write(CSR_JITTER_THRESHOLD, CSR_DATA_WIDTH'(THR_MAX));
      plan_write(CSR_JITTER_LIMIT, CSR_DATA_WIDTH'(LIMIT_MAX));
      plan_sample(e4, 1'b1, rsp_type'(e3));
      plan_sample(e4, 1'b1, rsp_type'(e3));
      plan_write(CSR_JITTER_LIMIT, 23'd5);
      plan_write(CSR_JITTER_THRESHOLD, 23'd256);
      plan_sample(e4, 1'b0, '0);
      plan_sample(e4, 1'b0, '0);
      plan_sample(e4, 1'b0, '0);
      plan_sample(make_sample(FORCE_MIN + 100, FORCE_MIN + 300, FORCE_MIN + 257,
                              FORCE_MIN + 256, FORCE_MIN, FORCE_MIN + 1000), 1'b0, '0);
      plan_write(CSR_FILTER_MODE, CSR_DATA_WIDTH'(MODE_LOWPASS));
      plan_write(CSR_LOWPASS_STEP_THRESHOLD, '0);
      plan_write(CSR_LOWPASS_GAIN_THRESHOLD, '0);
      plan_sample(e3, 1'b0, '0);
      plan_sample(make_sample(FORCE_MIN, FORCE_MAX, FORCE_MIN, FORCE_MAX, FORCE_MIN, FORCE_MAX),
                  1'b0, '0);
      plan_write(CSR_LOWPASS_STEP_THRESHOLD, CSR_DATA_WIDTH'(THR_MAX));
      plan_write(CSR_LOWPASS_GAIN_THRESHOLD, CSR_DATA_WIDTH'(GAIN_THR_MAX));
      plan_write(CSR_SPARE, '1);
      plan_sample(make_sample(1000, -1000, 1000, -1000, 1000, -1000), 1'b0, '0);
      plan_sample('0, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_write) begin
            drain_pipe();
            write_register(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_word(directed_rows[r].sample, directed_rows[r].known, directed_rows[r].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pipe();
         case ($urandom_range(0, 9))
            0, 1:       mode_pick = MODE_PASS;
            2, 3, 4, 5: mode_pick = MODE_JITTER;
            9:          mode_pick = MODE_SPARE;
            default:    mode_pick = MODE_LOWPASS;
         endcase
         case ($urandom_range(0, 7))
            0:       limit_pick = '0;
            1:       limit_pick = LIMIT_MAX;
            2:       limit_pick = 8'd1;
            default: limit_pick = LIMIT_WIDTH'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 7))
            0:       gain_pick = '0;
            1:       gain_pick = GAIN_THR_MAX;
            default: gain_pick = GAIN_THR_WIDTH'($urandom_range(1, 20));
         endcase
         write_register(CSR_FILTER_MODE,
                        {(CSR_DATA_WIDTH - MODE_WIDTH)'($urandom), mode_pick});
         write_register(CSR_JITTER_THRESHOLD, pick_threshold());
         write_register(CSR_JITTER_LIMIT, CSR_DATA_WIDTH'(limit_pick));
         write_register(CSR_LOWPASS_STEP_THRESHOLD, pick_threshold());
         write_register(CSR_LOWPASS_GAIN_THRESHOLD, CSR_DATA_WIDTH'(gain_pick));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // stall the result side for a while so the pipe backs up into req_ready
            if (phase % 3 == 1 && n == 40) begin
               hold_req = 1'b1;
               req_burst = 1'b1;
            end
            send_word(random_sample(), 1'b0, '0);
         end
      end

      drain_pipe();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
